/* rtl/tap_pkg.sv */
// shared types, register indexes, glyph codes and the segment table
// for the temperature alarm panel; no dependencies
`default_nettype none

package tap_pkg;

   localparam int TICK_BITS     = 16;
   localparam int LIMIT_BITS    = 7;
   localparam int INITIAL_LIMIT = 25;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE_TICKS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLINK_TICKS    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_STEP     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_MIN      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_MAX      = 3'd4;

   // register reset values
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] BLINK_RESET    = 16'd500;
   localparam logic [3:0]  STEP_RESET     = 4'd5;
   localparam logic [5:0]  MIN_RESET      = 6'd10;
   localparam logic [5:0]  MAX_RESET      = 6'd50;

   // glyph codes
   localparam logic [2:0] GLYPH_BLANK = 3'd0;
   localparam logic [2:0] GLYPH_0     = 3'd1;
   localparam logic [2:0] GLYPH_3     = 3'd2;
   localparam logic [2:0] GLYPH_7     = 3'd3;
   localparam logic [2:0] GLYPH_D     = 3'd4;
   localparam logic [2:0] GLYPH_F     = 3'd5;

   // distance thresholds, in degrees below the limit
   localparam int DIST_D    = 2;
   localparam int DIST_7    = 10;
   localparam int DIST_3    = 15;
   localparam int DIST_0    = 20;

   localparam logic [6:0] SEGS_OFF = 7'h7F;

   typedef struct packed {
      logic signed [7:0] temp_c;
      logic              up_level;
      logic              down_level;
   } req_type;

   typedef struct packed {
      logic       alarm_on;
      logic [6:0] limit_now;
      logic [2:0] glyph;
      logic [6:0] segments_n;
      logic       lit;
   } rsp_type;

   // active-low segments a..g in bits 0..6
   function automatic logic [6:0] glyph_segs(input logic [2:0] code);
      logic [6:0] segs;
      case (code)
         GLYPH_BLANK: segs = 7'h7F;
         GLYPH_0:     segs = 7'h40;
         GLYPH_3:     segs = 7'h30;
         GLYPH_7:     segs = 7'h78;
         GLYPH_D:     segs = 7'h21;
         GLYPH_F:     segs = 7'h0E;
         default:     segs = 7'h7F;
      endcase
      return segs;
   endfunction

endpackage

`default_nettype wire

/* rtl/tap_btn.sv */
// one push button: falling edge detect with a saturating debounce counter
// depends on tap_pkg
`default_nettype none

module tap_btn (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step_en,
   input  wire logic                         level,
   input  wire logic [tap_pkg::TICK_BITS-1:0] debounce,
   output logic                              press
);

   localparam logic [tap_pkg::TICK_BITS-1:0] SINCE_MAX = '1;

   logic                          prev_ff, prev_in;
   logic [tap_pkg::TICK_BITS-1:0] since_ff, since_in, since_inc;

   assign since_inc = (since_ff == SINCE_MAX) ? since_ff
                    : since_ff + {{(tap_pkg::TICK_BITS-1){1'b0}}, 1'b1};

   // press counts even if the limit can not move
   assign press = step_en && !level && prev_ff && (since_inc >= debounce);

   always_comb begin
      prev_in  = prev_ff;
      since_in = since_ff;
      if (step_en) begin
         prev_in  = level;
         since_in = press ? '0 : since_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b1;
         since_ff <= SINCE_MAX;
      end else begin
         prev_ff  <= prev_in;
         since_ff <= since_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/temperature_alarm_panel_unit.sv */
// temperature alarm panel top level: request register, limit and glyph logic,
// response register; depends on tap_pkg and tap_btn
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  tap_pkg::req_type
//   rsp      out        rsp_valid / rsp_ready  tap_pkg::rsp_type
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// one request per clock unless stalled; a response becomes valid once its
// request has passed the request register, then the response register
// the stage in front only stalls while the response register is full and
// rsp_ready is low; csr writes are always taken
// synchronous reset restores limit, counters, blink state, csr and valid bits
`default_nettype none

module temperature_alarm_panel_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire tap_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output tap_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tap_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [tap_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam logic [tap_pkg::TICK_BITS-1:0] SINCE_MAX = '1;

   // configuration
   logic [15:0] debounce_ff, blink_ticks_ff;
   logic [3:0]  step_ff;
   logic [5:0]  min_ff, max_ff;

   // pipeline
   logic              in_valid_ff, in_valid_in;
   tap_pkg::req_type  in_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tap_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              advance, fire;

   // item state
   logic [tap_pkg::LIMIT_BITS-1:0] limit_ff, limit_in, lim_up;
   logic [tap_pkg::TICK_BITS-1:0]  blink_since_ff, blink_since_in, blink_inc;
   logic                           shown_ff, shown_in;
   logic                           up_press, down_press;
   logic signed [9:0]              diff;
   logic                           alarm;
   logic [2:0]                     glyph;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   tap_btn u_btn_up (
      .clock    (clock),
      .reset    (reset),
      .step_en  (fire),
      .level    (in_data_ff.up_level),
      .debounce (debounce_ff),
      .press    (up_press)
   );

   tap_btn u_btn_down (
      .clock    (clock),
      .reset    (reset),
      .step_en  (fire),
      .level    (in_data_ff.down_level),
      .debounce (debounce_ff),
      .press    (down_press)
   );

   // up handled before down
   always_comb begin
      lim_up = limit_ff;
      if (up_press && (limit_ff < {1'b0, max_ff})) begin
         lim_up = limit_ff + {3'b000, step_ff};
      end
      limit_in = lim_up;
      if (down_press && (lim_up > {1'b0, min_ff})) begin
         limit_in = (lim_up >= {3'b000, step_ff}) ? lim_up - {3'b000, step_ff} : '0;
      end
      if (!fire) begin
         limit_in = limit_ff;
      end
   end

   // distance below the limit; alarm when it is zero or negative
   assign diff  = $signed({3'b000, limit_in})
                - $signed({{2{in_data_ff.temp_c[7]}}, in_data_ff.temp_c});
   assign alarm = (diff <= 10'sd0);

   always_comb begin
      if (alarm) begin
         glyph = tap_pkg::GLYPH_F;
      end else if (diff <= 10'(tap_pkg::DIST_D)) begin
         glyph = tap_pkg::GLYPH_D;
      end else if (diff <= 10'(tap_pkg::DIST_7)) begin
         glyph = tap_pkg::GLYPH_7;
      end else if (diff <= 10'(tap_pkg::DIST_3)) begin
         glyph = tap_pkg::GLYPH_3;
      end else if (diff <= 10'(tap_pkg::DIST_0)) begin
         glyph = tap_pkg::GLYPH_0;
      end else begin
         glyph = tap_pkg::GLYPH_BLANK;
      end
   end

   assign blink_inc = (blink_since_ff == SINCE_MAX) ? blink_since_ff
                    : blink_since_ff + {{(tap_pkg::TICK_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      blink_since_in = blink_since_ff;
      shown_in       = shown_ff;
      if (fire) begin
         blink_since_in = blink_inc;
         if (alarm) begin
            if (blink_inc > blink_ticks_ff) begin
               blink_since_in = '0;
               shown_in       = !shown_ff;
            end
         end else begin
            shown_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_data_in.alarm_on   = alarm;
      rsp_data_in.limit_now  = limit_in;
      rsp_data_in.glyph      = glyph;
      rsp_data_in.segments_n = shown_in ? tap_pkg::glyph_segs(glyph) : tap_pkg::SEGS_OFF;
      rsp_data_in.lit        = shown_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         limit_ff       <= 7'(tap_pkg::INITIAL_LIMIT);
         blink_since_ff <= SINCE_MAX;
         shown_ff       <= 1'b1;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         limit_ff       <= limit_in;
         blink_since_ff <= blink_since_in;
         shown_ff       <= shown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= tap_pkg::DEBOUNCE_RESET;
         blink_ticks_ff <= tap_pkg::BLINK_RESET;
         step_ff        <= tap_pkg::STEP_RESET;
         min_ff         <= tap_pkg::MIN_RESET;
         max_ff         <= tap_pkg::MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tap_pkg::CSR_DEBOUNCE_TICKS: debounce_ff    <= csr_data;
            tap_pkg::CSR_BLINK_TICKS:    blink_ticks_ff <= csr_data;
            tap_pkg::CSR_LIMIT_STEP:     step_ff        <= csr_data[3:0];
            tap_pkg::CSR_LIMIT_MIN:      min_ff         <= csr_data[5:0];
            tap_pkg::CSR_LIMIT_MAX:      max_ff         <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTH
   // blink-off only happens while the alarm is on
   a_dark_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.lit) |-> rsp_data_ff.alarm_on)
      else $error("display dark without alarm");

   // the F glyph and the alarm go together
   a_glyph_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.alarm_on == (rsp_data_ff.glyph == tap_pkg::GLYPH_F)))
      else $error("glyph disagrees with alarm");

   // the limit never goes past the largest reachable value
   a_limit_range: assert property (@(posedge clock) disable iff (reset)
      limit_ff <= 7'd77)
      else $error("limit out of range");

   // a stalled response keeps the held request in place
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_ready) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("request lost during stall");

   // limit only moves when a request is processed
   a_limit_moves_on_fire: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(limit_ff))
      else $error("limit changed without a request");
`endif

endmodule

`default_nettype wire
